@@ rtl/core/vitd_pkg.sv @@
// Package: constants, code table and branch metric helper for the Viterbi decoder
package vitd_pkg;
  localparam int NSTATES    = 16;
  localparam int MAX_STEPS  = 512;
  localparam int WORD_BITS  = 16;
  localparam int STEP_W     = $clog2(MAX_STEPS);
  localparam int CNT_W      = STEP_W + 1;
  localparam int MET_W      = 25;
  localparam int BM_W       = 9;
  localparam logic [MET_W-1:0] METRIC_MAX = 25'h0FFFFFF;

  function automatic logic [3:0] code_out(input logic [3:0] s, input logic b);
    logic [3:0] c0;
    case (s)
      4'd0: c0 = 4'd0;   4'd1: c0 = 4'd11;  4'd2: c0 = 4'd6;   4'd3: c0 = 4'd13;
      4'd4: c0 = 4'd5;   4'd5: c0 = 4'd14;  4'd6: c0 = 4'd3;   4'd7: c0 = 4'd8;
      4'd8: c0 = 4'd15;  4'd9: c0 = 4'd4;   4'd10: c0 = 4'd9;  4'd11: c0 = 4'd2;
      4'd12: c0 = 4'd10; 4'd13: c0 = 4'd1;  4'd14: c0 = 4'd12; default: c0 = 4'd7;
    endcase
    return b ? ~c0 : c0;
  endfunction

  // ((e - r)^2) >> 9 for one symbol; bit=1 means e=-127
  function automatic logic [6:0] sym_metric(input logic bit_one, input logic signed [7:0] r);
    logic signed [17:0] d;
    logic [17:0] sq;
    d  = bit_one ? (18'sd0 - 18'sd127 - 18'(r)) : (18'sd127 - 18'(r));
    sq = 18'($unsigned(d * d));
    return sq[15:9];
  endfunction
endpackage

@@ rtl/core/vitd_ram.sv @@
// Generic single-port-write, registered-read RAM
module vitd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/viterbi_decoder_r14_k5_soft_core.sv @@
// Top level: soft-decision rate 1/4 K=5 Viterbi decoder with traceback
//  channel | ports                                          | dir
//  in      | in_valid in_stall in_sym_0..3 in_last_step     | in
//  out     | out_valid out_stall out_decoded_word ... last  | out
// ACS: one butterfly unit looped over a step, after load, before write; in_stall held.
// Last step: min search over all states, then a read and an update per traced step,
// (registered RAM read), then one beat per word, each waiting on out_stall.
// rst_n synchronous: metrics reset, counters cleared. Survivor RAM is not cleared.
module viterbi_decoder_r14_k5_soft_core
  import vitd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_sym_0,
  input  logic signed [7:0] in_sym_1,
  input  logic signed [7:0] in_sym_2,
  input  logic signed [7:0] in_sym_3,
  input  logic              in_last_step,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_decoded_word,
  output logic [4:0]        out_word_index,
  output logic [4:0]        out_bit_count,
  output logic              out_overflow,
  output logic              out_last_word
);
  localparam logic [2:0] S_IDLE = 3'd0, S_ACS = 3'd1, S_WR = 3'd2, S_MIN = 3'd3,
                         S_TRD = 3'd4, S_TRB = 3'd5, S_OUT = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [MET_W-1:0] pm_r [NSTATES];
  logic [MET_W-1:0] nm_r [NSTATES];
  logic [15:0] dec_r;
  logic signed [7:0] sym_r [4];
  logic        last_r;
  logic [3:0]  k_r;
  logic [CNT_W-1:0] cnt_r, tb_r;
  logic        ovf_r;
  logic [3:0]  cur_r;
  logic [MET_W-1:0] best_r;
  logic [15:0] words_r [MAX_STEPS/WORD_BITS];
  logic [4:0]  w_r, nw_r;

  logic        ram_we;
  logic [STEP_W-1:0] ram_raddr;
  logic [15:0] ram_rdata;

  vitd_ram #(.WIDTH(16), .DEPTH(MAX_STEPS)) u_surv (
    .clk(clk), .we(ram_we), .waddr(cnt_r[STEP_W-1:0]), .wdata(dec_r),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // shared butterfly: predecessors k and k+8, next states 2k and 2k+1
  logic [3:0] s0, s1;
  logic [MET_W-1:0] c00, c01, c10, c11, m0, m1;
  logic d0, d1;
  function automatic logic [BM_W-1:0] bm(input logic [3:0] c,
                                         input logic signed [7:0] r0, input logic signed [7:0] r1,
                                         input logic signed [7:0] r2, input logic signed [7:0] r3);
    return BM_W'(sym_metric(c[3], r0)) + BM_W'(sym_metric(c[2], r1))
         + BM_W'(sym_metric(c[1], r2)) + BM_W'(sym_metric(c[0], r3));
  endfunction
  always_comb begin
    s0  = k_r;
    s1  = k_r + 4'd8;
    c00 = pm_r[s0] + MET_W'(bm(code_out(s0, 1'b0), sym_r[0], sym_r[1], sym_r[2], sym_r[3]));
    c10 = pm_r[s1] + MET_W'(bm(code_out(s1, 1'b0), sym_r[0], sym_r[1], sym_r[2], sym_r[3]));
    c01 = pm_r[s0] + MET_W'(bm(code_out(s0, 1'b1), sym_r[0], sym_r[1], sym_r[2], sym_r[3]));
    c11 = pm_r[s1] + MET_W'(bm(code_out(s1, 1'b1), sym_r[0], sym_r[1], sym_r[2], sym_r[3]));
    m0 = METRIC_MAX; d0 = 1'b0;
    if (c00 < m0) m0 = c00;
    if (c10 < m0) begin m0 = c10; d0 = 1'b1; end
    m1 = METRIC_MAX; d1 = 1'b0;
    if (c01 < m1) m1 = c01;
    if (c11 < m1) begin m1 = c11; d1 = 1'b1; end
  end

  logic accept;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign ram_we    = (state_r == S_WR) && (cnt_r < CNT_W'(MAX_STEPS));
  assign ram_raddr = STEP_W'(tb_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        if (cnt_r < CNT_W'(MAX_STEPS)) state_nxt = S_ACS;
        else if (in_last_step) state_nxt = S_MIN;
      end
      S_ACS:  if (k_r == 4'd7) state_nxt = S_WR;
      S_WR:   state_nxt = last_r ? S_MIN : S_IDLE;
      S_MIN:  if (k_r == 4'd15) state_nxt = (cnt_r == '0) ? S_IDLE
                                           : S_TRD;
      S_TRD:  state_nxt = S_TRB;
      S_TRB:  state_nxt = (tb_r == CNT_W'(1)) ? S_OUT : S_TRD;
      S_OUT:  if (!out_stall && w_r + 5'd1 == nw_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      k_r     <= '0;
      w_r     <= '0;
      for (int i = 0; i < NSTATES; i++) pm_r[i] <= (i == 0) ? '0 : METRIC_MAX;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (accept) begin
          sym_r[0] <= in_sym_0; sym_r[1] <= in_sym_1;
          sym_r[2] <= in_sym_2; sym_r[3] <= in_sym_3;
          last_r <= in_last_step;
          k_r <= '0;
          if (cnt_r >= CNT_W'(MAX_STEPS)) ovf_r <= 1'b1;
        end
        S_ACS: begin
          nm_r[{k_r[2:0], 1'b0}] <= m0;
          nm_r[{k_r[2:0], 1'b1}] <= m1;
          dec_r[{k_r[2:0], 1'b0}] <= d0;
          dec_r[{k_r[2:0], 1'b1}] <= d1;
          k_r <= k_r + 4'd1;
        end
        S_WR: begin
          for (int i = 0; i < NSTATES; i++) pm_r[i] <= nm_r[i];
          cnt_r <= cnt_r + CNT_W'(1);
          k_r <= '0;
        end
        S_MIN: begin
          if (k_r == 4'd0 || pm_r[k_r] < best_r) begin
            best_r <= pm_r[k_r];
            cur_r  <= k_r;
          end
          k_r  <= k_r + 4'd1;
          tb_r <= cnt_r;
          w_r  <= '0;
          nw_r <= 5'((cnt_r + CNT_W'(WORD_BITS - 1)) >> 4);
          for (int i = 0; i < MAX_STEPS/WORD_BITS; i++) words_r[i] <= '0;
        end
        S_TRD: ;
        S_TRB: begin
          words_r[ram_raddr[STEP_W-1:4]][ram_raddr[3:0]] <= cur_r[0];
          cur_r <= {ram_rdata[cur_r], cur_r[3:1]};
          tb_r  <= tb_r - CNT_W'(1);
        end
        S_OUT: if (!out_stall) begin
          w_r <= w_r + 5'd1;
          if (w_r + 5'd1 == nw_r) begin
            cnt_r <= '0;
            ovf_r <= 1'b0;
            for (int i = 0; i < NSTATES; i++) pm_r[i] <= (i == 0) ? '0 : METRIC_MAX;
          end
        end
        default: ;
      endcase
      if (state_r == S_MIN && k_r == 4'd15 && cnt_r == '0) begin
        ovf_r <= 1'b0;
        for (int i = 0; i < NSTATES; i++) pm_r[i] <= (i == 0) ? '0 : METRIC_MAX;
      end
    end
  end

  logic [CNT_W-1:0] rem;
  assign rem              = cnt_r - CNT_W'({w_r, 4'b0});
  assign out_valid        = (state_r == S_OUT);
  assign out_decoded_word = words_r[w_r];
  assign out_word_index   = w_r;
  assign out_bit_count    = (rem > CNT_W'(WORD_BITS)) ? 5'd16 : rem[4:0];
  assign out_overflow     = ovf_r;
  assign out_last_word    = (w_r + 5'd1 == nw_r);

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_STEPS)) else $error("step count overrun");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (nw_r != 5'd0 || cnt_r == CNT_W'(MAX_STEPS))) else $error("empty out");
  a_done_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> (cnt_r == '0 && !ovf_r))
    else $error("block state not restored");
endmodule
